FILE: hw/rtl/tts_pkg.sv
// tts_pkg: shared types and constants of the TLV type search block.
// Depends on nothing; imported by every module of the block.
package tts_pkg;

  localparam int unsigned BYTE_W                = 8;
  localparam int unsigned FIELD_W               = 17;
  localparam int unsigned HEADER_BYTES          = 5;
  localparam int unsigned MAX_MESSAGE_BYTES_DEF = 65536;

  typedef enum logic [1:0] {
    ST_FOUND     = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_MALFORMED = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  data_byte;
    logic               start_req;
    logic [FIELD_W-1:0] message_length;
    logic [BYTE_W-1:0]  wanted_type;
  } in_item_t;

  typedef struct packed {
    logic               valid;
    status_t            status;
    logic [FIELD_W-1:0] value_offset;
    logic [FIELD_W-1:0] value_length;
  } result_t;

endpackage

FILE: hw/rtl/tts_in_reg.sv
// tts_in_reg: input register stage of the TLV type search block.
// Depends on tts_pkg.
module tts_in_reg import tts_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  input  logic     advance,
  output logic     q_valid,
  output in_item_t q_item
);

  assign in_ready = !q_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_ready) begin
      q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      q_item <= in_item;
    end
  end

endmodule

FILE: hw/rtl/tts_parser.sv
// tts_parser: per-byte record header parser and skip counter.
// Depends on tts_pkg; produces at most one result word per processed byte.
module tts_parser import tts_pkg::*; #(
  parameter int unsigned MAX_MESSAGE_BYTES = MAX_MESSAGE_BYTES_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     fire,
  input  in_item_t item,
  output result_t  res
);

  localparam int unsigned LEN_W_RAW = $clog2(MAX_MESSAGE_BYTES + 1);
  localparam int unsigned LEN_W     = (LEN_W_RAW < FIELD_W) ? LEN_W_RAW : FIELD_W;
  localparam logic [2:0]  HDR_LAST  = 3'(HEADER_BYTES - 1);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SCAN,
    PH_DONE
  } phase_t;

  phase_t             phase, phase_next;
  logic [2:0]         header_count, header_count_next;
  logic [LEN_W-1:0]   position, position_next;
  logic [LEN_W-1:0]   remaining, remaining_next;
  logic [LEN_W-1:0]   skip_left, skip_left_next;
  logic [BYTE_W-1:0]  record_type, record_type_next;
  logic [LEN_W-1:0]   record_length, record_length_next;
  logic               length_ovf, length_ovf_next;
  logic [BYTE_W-1:0]  target_type, target_type_next;

  logic [LEN_W-1:0]   total_sat;
  logic [LEN_W+7:0]   shifted;

  assign total_sat = (32'(item.message_length) > 32'(MAX_MESSAGE_BYTES))
                     ? LEN_W'(MAX_MESSAGE_BYTES) : LEN_W'(item.message_length);

  always_comb begin
    logic done;
    done               = 1'b0;
    phase_next         = phase;
    header_count_next  = header_count;
    position_next      = position;
    remaining_next     = remaining;
    skip_left_next     = skip_left;
    record_type_next   = record_type;
    record_length_next = record_length;
    length_ovf_next    = length_ovf;
    target_type_next   = target_type;
    shifted            = '0;
    res                = '0;
    res.status         = ST_NOT_FOUND;

    if (item.start_req) begin
      target_type_next   = item.wanted_type;
      position_next      = '0;
      remaining_next     = total_sat;
      header_count_next  = '0;
      skip_left_next     = '0;
      record_type_next   = '0;
      record_length_next = '0;
      length_ovf_next    = 1'b0;
      phase_next         = PH_SCAN;
      if (total_sat == '0) begin
        done       = 1'b1;
        res.valid  = 1'b1;
        res.status = ST_EMPTY;
      end else if (total_sat < LEN_W'(HEADER_BYTES)) begin
        done       = 1'b1;
        res.valid  = 1'b1;
        res.status = ST_NOT_FOUND;
      end
    end

    if (!done && phase_next == PH_SCAN) begin
      position_next  = position_next + 1'b1;
      remaining_next = remaining_next - 1'b1;
      if (skip_left_next != '0) begin
        skip_left_next = skip_left_next - 1'b1;
        if (skip_left_next == '0 && remaining_next < LEN_W'(HEADER_BYTES)) begin
          done       = 1'b1;
          res.valid  = 1'b1;
          res.status = ST_NOT_FOUND;
        end
      end else begin
        if (header_count_next == 3'd0) begin
          record_type_next = item.data_byte;
        end else if (header_count_next == 3'd1) begin
          record_length_next = LEN_W'(item.data_byte);
          length_ovf_next    = (LEN_W < BYTE_W) ? ((item.data_byte >> LEN_W) != '0) : 1'b0;
        end else begin
          shifted            = {record_length_next, item.data_byte};
          record_length_next = shifted[LEN_W-1:0];
          length_ovf_next    = length_ovf_next || (shifted[LEN_W+7:LEN_W] != '0);
        end
        if (header_count_next != HDR_LAST) begin
          header_count_next = header_count_next + 3'd1;
        end else begin
          header_count_next = '0;
          if (length_ovf_next || record_length_next > remaining_next) begin
            done       = 1'b1;
            res.valid  = 1'b1;
            res.status = ST_MALFORMED;
          end else if (record_type_next == target_type_next) begin
            done             = 1'b1;
            res.valid        = 1'b1;
            res.status       = ST_FOUND;
            res.value_offset = FIELD_W'(position_next);
            res.value_length = FIELD_W'(record_length_next);
          end else begin
            skip_left_next = record_length_next;
            if (skip_left_next == '0 && remaining_next < LEN_W'(HEADER_BYTES)) begin
              done       = 1'b1;
              res.valid  = 1'b1;
              res.status = ST_NOT_FOUND;
            end
          end
        end
      end
    end

    if (done) begin
      phase_next = PH_DONE;
    end
    if (!fire) begin
      res.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      header_count  <= '0;
      position      <= '0;
      remaining     <= '0;
      skip_left     <= '0;
      record_type   <= '0;
      record_length <= '0;
      length_ovf    <= 1'b0;
      target_type   <= '0;
    end else if (fire) begin
      phase         <= phase_next;
      header_count  <= header_count_next;
      position      <= position_next;
      remaining     <= remaining_next;
      skip_left     <= skip_left_next;
      record_type   <= record_type_next;
      record_length <= record_length_next;
      length_ovf    <= length_ovf_next;
      target_type   <= target_type_next;
    end
  end

endmodule

FILE: hw/rtl/tts_out_reg.sv
// tts_out_reg: result register of the TLV type search block.
// Depends on tts_pkg.
module tts_out_reg import tts_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  result_t res,
  input  logic    out_ready,
  output logic    advance,
  output result_t out_q
);

  assign advance = !out_q.valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_q.valid <= 1'b0;
    end else if (advance) begin
      out_q.valid <= res.valid;
      if (res.valid) begin
        out_q.status       <= res.status;
        out_q.value_offset <= res.value_offset;
        out_q.value_length <= res.value_length;
      end
    end
  end

endmodule

FILE: hw/rtl/tlv_type_search_top.sv
// tlv_type_search_top: top level of the TLV type search block.
// Depends on tts_pkg, tts_in_reg, tts_parser and tts_out_reg.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one message byte per word, with
//   start_req marking the first byte; message_length and wanted_type are
//   sampled with that byte. Records are one type byte, a four-byte big-endian
//   length and the value; records of another type are skipped.
//   Output channel (out_valid/out_ready) carries one word per message:
//   status (found, not found, malformed length, empty) with the value's byte
//   offset and length when found. Bytes after a decision are dropped.
//   Throughput: one byte per cycle while no result is stalled on out_ready;
//   the header and skip counter update is combinational between the input
//   register and the result register. Result path: the deciding byte is held
//   in the input register and its result word is taken into the result register.
//   Reset: clears both register stages and returns the parser to idle.
//   Stall: while a result waits on out_ready, one more byte is held in the
//   input register and in_ready drops until the result is taken.
module tlv_type_search_top import tts_pkg::*; #(
  parameter int unsigned MAX_MESSAGE_BYTES = MAX_MESSAGE_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [BYTE_W-1:0]  data_byte,
  input  logic               start_req,
  input  logic [FIELD_W-1:0] message_length,
  input  logic [BYTE_W-1:0]  wanted_type,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic [FIELD_W-1:0] value_offset,
  output logic [FIELD_W-1:0] value_length
);

  in_item_t in_item;
  in_item_t q_item;
  logic     q_valid;
  logic     advance;
  result_t  res;
  result_t  out_q;

  assign in_item.data_byte      = data_byte;
  assign in_item.start_req      = start_req;
  assign in_item.message_length = message_length;
  assign in_item.wanted_type    = wanted_type;

  tts_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .advance  (advance),
    .q_valid  (q_valid),
    .q_item   (q_item)
  );

  tts_parser #(
    .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
  ) u_parser (
    .clk  (clk),
    .rst  (rst),
    .fire (q_valid && advance),
    .item (q_item),
    .res  (res)
  );

  tts_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .res       (res),
    .out_ready (out_ready),
    .advance   (advance),
    .out_q     (out_q)
  );

  assign out_valid    = out_q.valid;
  assign status       = out_q.status;
  assign value_offset = out_q.value_offset;
  assign value_length = out_q.value_length;

  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("in_ready low without a stalled result");

  a_zero_unless_found: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_FOUND) |-> (value_offset == '0 && value_length == '0))
    else $error("offset or length nonzero on a result other than found");

  a_found_after_header: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_FOUND) |-> (value_offset >= FIELD_W'(HEADER_BYTES)))
    else $error("found value offset inside the first header");

  a_result_needs_byte: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(q_valid))
    else $error("result word without a processed byte");

endmodule
